>>> rtl/core/qenc_pkg.sv
`default_nettype none

package qenc_pkg;

   localparam int INDEX_W = 5;
   localparam int PAIR_W  = 2;
   localparam int COUNT_W = 5;
   localparam int PPS_W   = 4;
   localparam int STEP_W  = 2;

   localparam int NUM_COUNTS = 2 ** COUNT_W;

   localparam logic [COUNT_W-1:0] COUNT_START     = 5'd8;
   localparam logic [PPS_W-1:0]   PPS_RESET       = 4'd4;
   localparam logic [3:0]         PAIR_INDEX_MASK = 4'hF;

   // delta and step share one two-bit signed coding
   localparam logic [STEP_W-1:0] DELTA_NONE = 2'b00;
   localparam logic [STEP_W-1:0] DELTA_FWD  = 2'b01;
   localparam logic [STEP_W-1:0] DELTA_BACK = 2'b11;

   // indexed by {previous pair, current pair}
   localparam logic [STEP_W-1:0] TRANSITION_TABLE [16] = '{
      DELTA_NONE, DELTA_FWD,  DELTA_BACK, DELTA_NONE,
      DELTA_BACK, DELTA_NONE, DELTA_NONE, DELTA_FWD,
      DELTA_FWD,  DELTA_NONE, DELTA_NONE, DELTA_BACK,
      DELTA_NONE, DELTA_BACK, DELTA_FWD,  DELTA_NONE
   };

   typedef struct packed {
      logic [PAIR_W-1:0]  pair;
      logic [COUNT_W-1:0] count;
      logic               forward;
   } entry_type;

   localparam entry_type ENTRY_RESET = '{pair: '0, count: COUNT_START, forward: 1'b0};

   typedef struct packed {
      logic                  busy;
      logic [NUM_COUNTS-1:0] multiple;
   } step_table_type;

endpackage

`default_nettype wire

>>> rtl/core/qenc_if.sv
`default_nettype none

interface qenc_req_if;
   logic                         valid;
   logic                         ready;
   logic [qenc_pkg::INDEX_W-1:0] encoder_index;
   logic [qenc_pkg::PAIR_W-1:0]  pair_bits;

   modport source (output valid, output encoder_index, output pair_bits, input ready);
   modport sink   (input valid, input encoder_index, input pair_bits, output ready);
endinterface

interface qenc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [qenc_pkg::STEP_W-1:0] step;

   modport source (output valid, output step, input ready);
   modport sink   (input valid, input step, output ready);
endinterface

interface qenc_csr_if;
   logic                       valid;
   logic                       ready;
   logic [qenc_pkg::PPS_W-1:0] step_length;

   modport source (output valid, output step_length, input ready);
   modport sink   (input valid, input step_length, output ready);
endinterface

`default_nettype wire

>>> rtl/core/qenc_state_mem.sv
`default_nettype none

module qenc_state_mem #(
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                rd_en,
   input  wire logic [ADDR_W-1:0]   rd_addr,
   output qenc_pkg::entry_type      rd_data,
   input  wire logic                wr_en,
   input  wire logic [ADDR_W-1:0]   wr_addr,
   input  wire qenc_pkg::entry_type wr_data
);

   qenc_pkg::entry_type mem [DEPTH];
   qenc_pkg::entry_type rd_data_ff;
   logic [DEPTH-1:0]    written_ff;
   logic [DEPTH-1:0]    written_in;
   logic                rd_hit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      written_in = written_ff;
      if (wr_en) begin
         written_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
         rd_hit_ff  <= 1'b0;
      end else begin
         written_ff <= written_in;
         if (rd_en) begin
            rd_hit_ff <= written_ff[rd_addr];
         end
      end
   end

   // entries not yet written read as their reset value
   assign rd_data = rd_hit_ff ? rd_data_ff : qenc_pkg::ENTRY_RESET;

endmodule

`default_nettype wire

>>> rtl/core/qenc_step_table.sv
`default_nettype none

module qenc_step_table (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       wr_en,
   input  wire logic [qenc_pkg::PPS_W-1:0] wr_data,
   output qenc_pkg::step_table_type        table_out
);

   logic [qenc_pkg::PPS_W-1:0]      div_ff;
   logic [qenc_pkg::PPS_W-1:0]      div_in;
   logic [qenc_pkg::PPS_W-1:0]      rem_ff;
   logic [qenc_pkg::PPS_W-1:0]      rem_in;
   logic [qenc_pkg::COUNT_W-1:0]    idx_ff;
   logic [qenc_pkg::COUNT_W-1:0]    idx_in;
   logic                            busy_ff;
   logic                            busy_in;
   logic [qenc_pkg::NUM_COUNTS-1:0] multiple_ff;
   logic [qenc_pkg::NUM_COUNTS-1:0] multiple_in;
   logic [qenc_pkg::PPS_W:0]        rem_sum;

   // sweep all counts once, tracking count mod divisor incrementally
   always_comb begin
      div_in      = div_ff;
      rem_in      = rem_ff;
      idx_in      = idx_ff;
      busy_in     = busy_ff;
      multiple_in = multiple_ff;
      rem_sum     = {1'b0, rem_ff} + 1'b1;
      if (wr_en) begin
         div_in  = (wr_data == '0) ? qenc_pkg::PPS_W'(1) : wr_data;
         rem_in  = '0;
         idx_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         multiple_in[idx_ff] = (rem_ff == '0);
         rem_in  = (rem_sum == {1'b0, div_ff}) ? '0 : rem_sum[qenc_pkg::PPS_W-1:0];
         idx_in  = idx_ff + 1'b1;
         busy_in = (idx_ff != '1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff  <= qenc_pkg::PPS_RESET;
         rem_ff  <= '0;
         idx_ff  <= '0;
         busy_ff <= 1'b1;
      end else begin
         div_ff  <= div_in;
         rem_ff  <= rem_in;
         idx_ff  <= idx_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      multiple_ff <= multiple_in;
   end

   assign table_out = '{busy: busy_ff, multiple: multiple_ff};

endmodule

`default_nettype wire

>>> rtl/core/quadrature_encoder_step_counter.sv
// Quadrature step counter for a bank of encoders sampled one at a time.
// req_chan: one request per sample, carrying encoder_index and pair_bits.
// rsp_chan: exactly one step per request, in request order: +1, -1 or 0.
// csr_chan: writes step_length, the pulses per step (0 acts as 1); always ready.
// Per-encoder state (previous pair, pulse count, direction) sits in one
// synchronous RAM, read when a request is taken and written back when the step
// is loaded into the output register, which may wait on a stalled receiver.
// The step is computed in the CALC state and then held in the output register.
// A new request is taken only once the previous one has left the CALC state.
// After reset, and after each step_length write, a sweep over all counts builds the
// table of counts that complete a step; no request is taken during it.
// Reset returns every encoder to pair 0, count 8, backward.
// The step sits in an output register, so the next request can be accepted while
// it waits; if the receiver stalls longer, the following request waits in the
// block and req_chan.ready stays low until the output register frees.
// Samples with an encoder_index at or beyond NUM_ENCODERS give 0 and touch nothing.
`default_nettype none

module quadrature_encoder_step_counter #(
   parameter int NUM_ENCODERS = 32
) (
   input wire logic   clock,
   input wire logic   reset,
   qenc_req_if.sink   req_chan,
   qenc_rsp_if.source rsp_chan,
   qenc_csr_if.sink   csr_chan
);

   localparam int ADDR_W = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;
   localparam int EXT_W  = (ADDR_W > qenc_pkg::INDEX_W) ? ADDR_W : qenc_pkg::INDEX_W;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_CALC = 1'b1;

   logic                          state_ff;
   logic                          state_in;
   logic [ADDR_W-1:0]             addr_ff;
   logic [qenc_pkg::PAIR_W-1:0]   pair_ff;
   logic                          in_range_ff;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [qenc_pkg::STEP_W-1:0]   rsp_step_ff;
   logic [qenc_pkg::STEP_W-1:0]   step_calc;

   logic [EXT_W-1:0]              index_ext;
   logic                          req_take;
   logic                          slot_free;
   logic                          load;
   logic                          wr_en;
   qenc_pkg::entry_type           rd_data;
   qenc_pkg::entry_type           wr_data;
   qenc_pkg::step_table_type      table_out;

   logic [3:0]                    trans_idx;
   logic [qenc_pkg::STEP_W-1:0]   delta;
   logic                          fwd;
   logic [qenc_pkg::COUNT_W-1:0]  count_next;

   assign index_ext = EXT_W'(req_chan.encoder_index);
   assign req_chan.ready = (state_ff == S_IDLE) && !table_out.busy;
   assign req_take  = req_chan.valid && req_chan.ready;
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign load      = (state_ff == S_CALC) && slot_free;
   assign csr_chan.ready = 1'b1;

   qenc_step_table u_step_table (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (csr_chan.valid),
      .wr_data   (csr_chan.step_length),
      .table_out (table_out)
   );

   qenc_state_mem #(
      .DEPTH  (NUM_ENCODERS),
      .ADDR_W (ADDR_W)
   ) u_state_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_take),
      .rd_addr (index_ext[ADDR_W-1:0]),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (addr_ff),
      .wr_data (wr_data)
   );

   // decode the transition and update the entry
   always_comb begin
      trans_idx  = {rd_data.pair, pair_ff} & qenc_pkg::PAIR_INDEX_MASK;
      delta      = qenc_pkg::TRANSITION_TABLE[trans_idx];
      fwd        = (delta == qenc_pkg::DELTA_FWD);
      count_next = fwd ? (rd_data.count + 1'b1) : (rd_data.count - 1'b1);
      wr_data    = rd_data;
      wr_data.pair = pair_ff;
      step_calc  = qenc_pkg::DELTA_NONE;
      if (delta != qenc_pkg::DELTA_NONE) begin
         wr_data.count   = count_next;
         wr_data.forward = fwd;
         if ((rd_data.forward == fwd) && table_out.multiple[count_next]) begin
            wr_data.count = qenc_pkg::COUNT_START;
            step_calc     = delta;
         end
      end
      if (!in_range_ff) begin
         step_calc = qenc_pkg::DELTA_NONE;
      end
   end

   assign wr_en = load && in_range_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         addr_ff     <= index_ext[ADDR_W-1:0];
         pair_ff     <= req_chan.pair_bits;
         in_range_ff <= (32'(req_chan.encoder_index) < 32'(NUM_ENCODERS));
      end
      if (load) begin
         rsp_step_ff <= step_calc;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.step  = rsp_step_ff;

`ifndef NO_ASSERTIONS
   a_no_take_in_sweep: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |-> !table_out.busy)
      else $error("request taken during step table sweep");

   a_write_in_calc: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_CALC) && slot_free)
      else $error("state write outside update cycle");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_chan.valid && (rsp_chan.step == $past(step_calc)))
      else $error("loaded step not presented");

   a_step_code: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.step != 2'b10))
      else $error("illegal step code");
`endif

endmodule

`default_nettype wire
